@@ rtl/sclb_pkg.sv @@
// ============================================================================
// sclb_pkg
// Shared types and constants for the serial command-line blink controller.
// ============================================================================
package sclb_pkg;

    localparam int LINE_BYTES = 32;
    localparam int IDX_W      = $clog2(LINE_BYTES);
    localparam int FILL_MAX   = LINE_BYTES - 2;
    localparam int PREFIX_LEN = 7;
    localparam int SHORT_LEN  = 6;

    localparam logic [31:0] PERIOD_RESET = 32'd1000;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic [55:0] TXT_PERIOD = "period ";
    localparam logic [55:0] TXT_ON     = {"led on", 8'h00};
    localparam logic [55:0] TXT_OFF    = "led off";
    localparam logic [55:0] TXT_STATUS = {"status", 8'h00};

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] STAT_PERIOD  = 3'd0;
    localparam logic [2:0] STAT_LED_ON  = 3'd1;
    localparam logic [2:0] STAT_LED_OFF = 3'd2;
    localparam logic [2:0] STAT_STATUS  = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_DIGIT,
        PH_DONE
    } t_phase;

    function automatic logic [7:0] txt_byte(input logic [55:0] txt, input logic [2:0] pos);
        logic [7:0] b;
        b = txt[8 * (PREFIX_LEN - 1 - int'(pos)) +: 8];
        return b;
    endfunction

endpackage

@@ rtl/serial_command_line_blink_control.sv @@
// ============================================================================
// serial_command_line_blink_control
// Echoes received characters into a line store, runs line commands on newline
// and toggles the LED from millisecond ticks.
// ============================================================================
// Order: a tick or character goes from S_IDLE to S_EMIT, which loads its beats
// into the output register as it frees; a newline walks the line in S_WALK, one
// line-store read per cycle through the registered read port, then S_FIN, S_EMIT
// (an empty line skips S_WALK). Throughput: one item in flight; the next is
// taken the cycle after its last beat is loaded into the output register.
// Reset: synchronous, clears line fill, uptime, LED; period returns to 1000.
module serial_command_line_blink_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic [31:0] o_period_value,
    output logic [31:0] o_uptime_value,
    output logic        o_led_out,
    output logic        o_last_of_run
);

    localparam int IDX_W = sclb_pkg::IDX_W;

    sclb_pkg::t_state r_state, n_state;
    sclb_pkg::t_phase r_phase, n_phase;

    logic [IDX_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_rd_addr, n_rd_addr;
    logic [IDX_W-1:0] r_byte_pos, n_byte_pos;
    logic             r_byte_vld, n_byte_vld;
    logic [7:0]       r_rd_data;
    logic             store_wr;

    logic [31:0] r_period, n_period;
    logic [31:0] r_since, n_since;
    logic [31:0] r_uptime, n_uptime;
    logic        r_led, n_led;

    logic        r_m_period, n_m_period;
    logic        r_m_on, n_m_on;
    logic        r_m_off, n_m_off;
    logic        r_m_status, n_m_status;
    logic        r_neg, n_neg;
    logic [31:0] r_value, n_value;

    logic [1:0] r_em_cnt, n_em_cnt;
    logic [1:0] r_em_kind, n_em_kind;
    logic [7:0] r_em_data, n_em_data;
    logic [2:0] r_em_status, n_em_status;

    logic        r_o_valid, n_o_valid;
    logic [1:0]  r_o_kind, n_o_kind;
    logic [7:0]  r_o_data, n_o_data;
    logic [2:0]  r_o_status, n_o_status;
    logic [31:0] r_o_period, n_o_period;
    logic [31:0] r_o_uptime, n_o_uptime;
    logic        r_o_led, n_o_led;
    logic        r_o_last, n_o_last;

    logic [31:0] since_inc;
    logic [7:0]  cur;
    logic [2:0]  pos3;
    logic        cur_digit;
    logic [31:0] value_step;

    logic [7:0] line_mem [sclb_pkg::LINE_BYTES];

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            line_mem[r_fill] <= i_char_byte;
        end
        r_rd_data <= line_mem[r_rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_rd_addr   = r_rd_addr;
        n_byte_pos  = r_byte_pos;
        n_byte_vld  = r_byte_vld;
        n_period    = r_period;
        n_since     = r_since;
        n_uptime    = r_uptime;
        n_led       = r_led;
        n_m_period  = r_m_period;
        n_m_on      = r_m_on;
        n_m_off     = r_m_off;
        n_m_status  = r_m_status;
        n_neg       = r_neg;
        n_value     = r_value;
        n_em_cnt    = r_em_cnt;
        n_em_kind   = r_em_kind;
        n_em_data   = r_em_data;
        n_em_status = r_em_status;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_kind    = r_o_kind;
        n_o_data    = r_o_data;
        n_o_status  = r_o_status;
        n_o_period  = r_o_period;
        n_o_uptime  = r_o_uptime;
        n_o_led     = r_o_led;
        n_o_last    = r_o_last;
        store_wr    = 1'b0;
        o_ready     = (r_state == sclb_pkg::S_IDLE);

        since_inc  = r_since + 32'd1;
        cur        = r_rd_data;
        pos3       = r_byte_pos[2:0];
        cur_digit  = (cur inside {[sclb_pkg::CH_ZERO:sclb_pkg::CH_NINE]});
        value_step = {r_value[28:0], 3'b000} + {r_value[30:0], 1'b0}
                   + {28'd0, 4'(cur - sclb_pkg::CH_ZERO)};

        case (r_state)
            sclb_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode) begin
                        n_uptime = r_uptime + 32'd1;
                        if (since_inc >= r_period) begin
                            n_since = '0;
                            n_led   = ~r_led;
                        end else begin
                            n_since = since_inc;
                        end
                        n_em_cnt    = 2'd1;
                        n_em_kind   = sclb_pkg::KIND_TICK;
                        n_em_data   = '0;
                        n_em_status = '0;
                        n_state     = sclb_pkg::S_EMIT;
                    end else if (i_char_byte == sclb_pkg::CH_LF) begin
                        n_m_period = 1'b1;
                        n_m_on     = 1'b1;
                        n_m_off    = 1'b1;
                        n_m_status = 1'b1;
                        n_neg      = 1'b0;
                        n_value    = '0;
                        n_phase    = sclb_pkg::PH_BLANK;
                        n_rd_addr  = '0;
                        n_byte_vld = 1'b0;
                        n_state    = (r_fill == '0) ? sclb_pkg::S_FIN : sclb_pkg::S_WALK;
                    end else if (i_char_byte == sclb_pkg::CH_BS ||
                                 i_char_byte == sclb_pkg::CH_DEL) begin
                        if (r_fill != '0) begin
                            n_fill      = r_fill - IDX_W'(1);
                            n_em_cnt    = 2'd3;
                            n_em_kind   = sclb_pkg::KIND_ECHO;
                            n_em_data   = sclb_pkg::CH_BS;
                            n_em_status = '0;
                            n_state     = sclb_pkg::S_EMIT;
                        end
                    end else if (i_char_byte != sclb_pkg::CH_CR) begin
                        if (r_fill < IDX_W'(sclb_pkg::FILL_MAX)) begin
                            store_wr = 1'b1;
                            n_fill   = r_fill + IDX_W'(1);
                        end
                        n_em_cnt    = 2'd1;
                        n_em_kind   = sclb_pkg::KIND_ECHO;
                        n_em_data   = i_char_byte;
                        n_em_status = '0;
                        n_state     = sclb_pkg::S_EMIT;
                    end
                end
            end
            sclb_pkg::S_WALK: begin
                n_byte_vld = 1'b0;
                if (r_rd_addr != r_fill) begin
                    n_byte_vld = 1'b1;
                    n_byte_pos = r_rd_addr;
                    n_rd_addr  = r_rd_addr + IDX_W'(1);
                end else if (r_byte_vld) begin
                    n_state = sclb_pkg::S_FIN;
                end
                if (r_byte_vld) begin
                    if (r_byte_pos < IDX_W'(sclb_pkg::PREFIX_LEN)) begin
                        n_m_period = r_m_period
                                   && (cur == sclb_pkg::txt_byte(sclb_pkg::TXT_PERIOD, pos3));
                        n_m_off    = r_m_off
                                   && (cur == sclb_pkg::txt_byte(sclb_pkg::TXT_OFF, pos3));
                        if (r_byte_pos < IDX_W'(sclb_pkg::SHORT_LEN)) begin
                            n_m_on     = r_m_on
                                       && (cur == sclb_pkg::txt_byte(sclb_pkg::TXT_ON, pos3));
                            n_m_status = r_m_status
                                       && (cur == sclb_pkg::txt_byte(sclb_pkg::TXT_STATUS, pos3));
                        end
                    end else begin
                        case (r_phase)
                            sclb_pkg::PH_BLANK: begin
                                if (cur inside {sclb_pkg::CH_SPACE,
                                                [sclb_pkg::CH_TAB:sclb_pkg::CH_CR]}) begin
                                    n_phase = sclb_pkg::PH_BLANK;
                                end else if (cur == sclb_pkg::CH_PLUS ||
                                             cur == sclb_pkg::CH_MINUS) begin
                                    n_neg   = (cur == sclb_pkg::CH_MINUS);
                                    n_phase = sclb_pkg::PH_DIGIT;
                                end else if (cur_digit) begin
                                    n_value = value_step;
                                    n_phase = sclb_pkg::PH_DIGIT;
                                end else begin
                                    n_phase = sclb_pkg::PH_DONE;
                                end
                            end
                            sclb_pkg::PH_DIGIT: begin
                                if (cur_digit) begin
                                    n_value = value_step;
                                end else begin
                                    n_phase = sclb_pkg::PH_DONE;
                                end
                            end
                            default: begin
                                n_phase = sclb_pkg::PH_DONE;
                            end
                        endcase
                    end
                end
            end
            sclb_pkg::S_FIN: begin
                n_em_cnt  = 2'd1;
                n_em_kind = sclb_pkg::KIND_CMD;
                n_em_data = '0;
                if (r_m_period && r_fill >= IDX_W'(sclb_pkg::PREFIX_LEN)) begin
                    n_period    = r_neg ? (32'd0 - r_value) : r_value;
                    n_em_status = sclb_pkg::STAT_PERIOD;
                end else if (r_m_on && r_fill == IDX_W'(sclb_pkg::SHORT_LEN)) begin
                    n_led       = 1'b1;
                    n_em_status = sclb_pkg::STAT_LED_ON;
                end else if (r_m_off && r_fill == IDX_W'(sclb_pkg::PREFIX_LEN)) begin
                    n_led       = 1'b0;
                    n_em_status = sclb_pkg::STAT_LED_OFF;
                end else if (r_m_status && r_fill == IDX_W'(sclb_pkg::SHORT_LEN)) begin
                    n_em_status = sclb_pkg::STAT_STATUS;
                end else begin
                    n_em_status = sclb_pkg::STAT_UNKNOWN;
                end
                n_fill  = '0;
                n_state = sclb_pkg::S_EMIT;
            end
            sclb_pkg::S_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = r_em_kind;
                    n_o_data   = (r_em_cnt == 2'd2) ? sclb_pkg::CH_SPACE : r_em_data;
                    n_o_status = r_em_status;
                    n_o_period = r_period;
                    n_o_uptime = r_uptime;
                    n_o_led    = r_led;
                    n_o_last   = (r_em_cnt == 2'd1);
                    n_em_cnt   = r_em_cnt - 2'd1;
                    if (r_em_cnt == 2'd1) begin
                        n_state = sclb_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sclb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sclb_pkg::S_IDLE;
            r_fill    <= '0;
            r_period  <= sclb_pkg::PERIOD_RESET;
            r_since   <= '0;
            r_uptime  <= '0;
            r_led     <= 1'b0;
            r_o_valid <= 1'b0;
            r_em_cnt  <= '0;
            r_byte_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_period  <= n_period;
            r_since   <= n_since;
            r_uptime  <= n_uptime;
            r_led     <= n_led;
            r_o_valid <= n_o_valid;
            r_em_cnt  <= n_em_cnt;
            r_byte_vld <= n_byte_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase     <= n_phase;
        r_rd_addr   <= n_rd_addr;
        r_byte_pos  <= n_byte_pos;
        r_m_period  <= n_m_period;
        r_m_on      <= n_m_on;
        r_m_off     <= n_m_off;
        r_m_status  <= n_m_status;
        r_neg       <= n_neg;
        r_value     <= n_value;
        r_em_kind   <= n_em_kind;
        r_em_data   <= n_em_data;
        r_em_status <= n_em_status;
        r_o_kind    <= n_o_kind;
        r_o_data    <= n_o_data;
        r_o_status  <= n_o_status;
        r_o_period  <= n_o_period;
        r_o_uptime  <= n_o_uptime;
        r_o_led     <= n_o_led;
        r_o_last    <= n_o_last;
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_data_byte    = r_o_data;
    assign o_status       = r_o_status;
    assign o_period_value = r_o_period;
    assign o_uptime_value = r_o_uptime;
    assign o_led_out      = r_o_led;
    assign o_last_of_run  = r_o_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= IDX_W'(sclb_pkg::FILL_MAX))
        else $error("line fill beyond limit");

    a_walk_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sclb_pkg::S_WALK && r_byte_vld) |-> (r_byte_pos < r_fill))
        else $error("line walk read past fill");

    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sclb_pkg::S_EMIT) |-> (r_em_cnt != 2'd0))
        else $error("emit state with no beat pending");

    a_tick_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_opcode)
            |=> (r_state == sclb_pkg::S_EMIT && r_em_cnt == 2'd1
                 && r_uptime == $past(r_uptime) + 32'd1))
        else $error("tick did not advance uptime");

    a_uptime_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && o_ready && i_opcode) |=> $stable(r_uptime))
        else $error("uptime moved without a tick");

endmodule
